// ===== sv/tlv_pkt_pkg.sv =====
// Package for the TLV packet deframer: header layout constants and the result record.
// No dependencies. Used by tlv_packet_deframer_top and its testbench.
`timescale 1ns / 1ps
`default_nettype none
package tlv_pkt_pkg;

    localparam int unsigned HEADER_BYTES = 7;
    localparam int unsigned IDX_W        = 3;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned ID_W         = 32;
    localparam int unsigned LEN_W        = 16;

    localparam logic [IDX_W-1:0] IDX_TYPE    = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_ID_LAST = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_LEN_LO  = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(HEADER_BYTES - 1);

    typedef struct packed {
        logic [BYTE_W-1:0] packet_type;
        logic [ID_W-1:0]   send_id;
        logic [LEN_W-1:0]  payload_length;
        logic [BYTE_W-1:0] payload_byte;
        logic              has_byte;
        logic              last;
    } t_result;

endpackage
`default_nettype wire

// ===== sv/tlv_packet_deframer_top.sv =====
// Top level of the TLV packet deframer: header collection, payload tagging and output skid.
// Depends on tlv_pkt_pkg.
//
// Usage: the input channel takes one stream byte per item on i_data_byte. Each packet is
// a 7-byte header (type, 32-bit send id little-endian, 16-bit length little-endian)
// followed by the payload. Header bytes give no result. Every payload byte gives one
// result item carrying the packet's type, id, length and the byte, with o_last set on
// the final byte. A packet of length zero gives a single result with o_has_byte clear
// and o_last set, when its final header byte is taken.
// A result is registered in the output register, or in the skid register while the receiver
// stalls. Throughput: one byte per cycle while the skid register is empty, set by the single
// registered pass from the header and count registers to the output register.
// Reset clears the header position, the held header and the payload count, and drops
// any result not yet delivered. When the receiver stalls, the output register holds its
// item and one more result is kept in a skid register; o_in_ready falls only while that
// skid register is occupied.
`timescale 1ns / 1ps
`default_nettype none
module tlv_packet_deframer_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [tlv_pkt_pkg::BYTE_W-1:0] i_data_byte,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [tlv_pkt_pkg::BYTE_W-1:0]      o_packet_type,
    output logic [tlv_pkt_pkg::ID_W-1:0]        o_send_id,
    output logic [tlv_pkt_pkg::LEN_W-1:0]       o_payload_length,
    output logic [tlv_pkt_pkg::BYTE_W-1:0]      o_payload_byte,
    output logic                                o_has_byte,
    output logic                                o_last
);
    import tlv_pkt_pkg::*;

    logic              r_in_payload, n_in_payload;
    logic [IDX_W-1:0]  r_hdr_idx, n_hdr_idx;
    logic [BYTE_W-1:0] r_held_type, n_held_type;
    logic [ID_W-1:0]   r_held_id, n_held_id;
    logic [LEN_W-1:0]  r_held_len, n_held_len;
    logic [LEN_W-1:0]  r_remaining, n_remaining;

    logic              r_out_valid, r_skid_valid;
    t_result           r_out, r_skid;
    t_result           n_res;
    logic              n_res_valid;

    logic              accept;
    logic              take;
    logic [IDX_W-1:0]  idx;
    logic [LEN_W-1:0]  rem_dec;

    assign o_in_ready = !r_skid_valid;
    assign accept     = i_in_valid && o_in_ready;
    assign take       = r_out_valid && i_out_ready;
    assign idx        = (r_hdr_idx > IDX_LAST) ? IDX_TYPE : r_hdr_idx;
    assign rem_dec    = r_remaining - LEN_W'(1);

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_idx    = r_hdr_idx;
        n_held_type  = r_held_type;
        n_held_id    = r_held_id;
        n_held_len   = r_held_len;
        n_remaining  = r_remaining;
        n_res_valid  = 1'b0;
        n_res        = '0;
        if (r_in_payload) begin
            n_remaining = rem_dec;
            n_res_valid = 1'b1;
            n_res.payload_byte = i_data_byte;
            n_res.has_byte     = 1'b1;
            if (rem_dec == '0) begin
                n_res.last   = 1'b1;
                n_in_payload = 1'b0;
                n_hdr_idx    = IDX_TYPE;
            end
        end else begin
            if (idx == IDX_TYPE) begin
                n_held_type = i_data_byte;
            end else if (idx <= IDX_ID_LAST) begin
                n_held_id[(idx - IDX_W'(1)) * BYTE_W +: BYTE_W] = i_data_byte;
            end else begin
                n_held_len[(idx - IDX_LEN_LO) * BYTE_W +: BYTE_W] = i_data_byte;
            end
            if (idx != IDX_LAST) begin
                n_hdr_idx = idx + IDX_W'(1);
            end else begin
                n_hdr_idx = IDX_TYPE;
                if (n_held_len == '0) begin
                    n_res_valid = 1'b1;
                    n_res.last  = 1'b1;
                end else begin
                    n_in_payload = 1'b1;
                    n_remaining  = n_held_len;
                end
            end
        end
        n_res.packet_type    = n_held_type;
        n_res.send_id        = n_held_id;
        n_res.payload_length = n_held_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_idx    <= IDX_TYPE;
            r_held_type  <= '0;
            r_held_id    <= '0;
            r_held_len   <= '0;
            r_remaining  <= '0;
        end else if (accept) begin
            r_in_payload <= n_in_payload;
            r_hdr_idx    <= n_hdr_idx;
            r_held_type  <= n_held_type;
            r_held_id    <= n_held_id;
            r_held_len   <= n_held_len;
            r_remaining  <= n_remaining;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept && n_res_valid;
            end
        end else if (accept && n_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (accept && n_res_valid) begin
            r_skid <= n_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_packet_type    = r_out.packet_type;
    assign o_send_id        = r_out.send_id;
    assign o_payload_length = r_out.payload_length;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_has_byte       = r_out.has_byte;
    assign o_last           = r_out.last;

    // The skid register is only ever filled behind a waiting output item.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an item while the output register is empty");

    // A packet in its payload phase always has bytes still to come.
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_remaining != '0))
        else $error("payload phase entered with no bytes remaining");

    // After every payload byte taken, the output register holds a valid item on the next cycle.
    a_payload_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_in_payload) |=> r_out_valid)
        else $error("payload byte accepted without a result");

    // The header position never reaches the header length.
    a_hdr_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_idx <= IDX_LAST)
        else $error("header position out of range");

endmodule
`default_nettype wire

// ===== tb/sv/tb_tlv_packet_deframer_top.sv =====
// Self-checking testbench for tlv_packet_deframer_top: directed and random byte streams.
// Each accepted byte goes through a local deframer that stores the expected results.
// Depends on tlv_pkt_pkg and tlv_packet_deframer_top.
`timescale 1ns / 1ps
module tb_tlv_packet_deframer_top;
    import tlv_pkt_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [BYTE_W-1:0] i_data_byte;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [BYTE_W-1:0] o_packet_type;
    logic [ID_W-1:0]   o_send_id;
    logic [LEN_W-1:0]  o_payload_length;
    logic [BYTE_W-1:0] o_payload_byte;
    logic              o_has_byte;
    logic              o_last;

    tlv_packet_deframer_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_packet_type    (o_packet_type),
        .o_send_id        (o_send_id),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_has_byte       (o_has_byte),
        .o_last           (o_last)
    );

    // Local copy of the deframer state.
    logic              in_payload;
    logic [IDX_W-1:0]  hdr_pos;
    logic [BYTE_W-1:0] cur_type;
    logic [ID_W-1:0]   cur_id;
    logic [LEN_W-1:0]  cur_len;
    logic [LEN_W-1:0]  bytes_left;

    t_result           tagged_bytes_due [64];
    logic [5:0]        due_wr;
    logic [5:0]        due_rd;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                fail_count;
    int                quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result make_result(input logic [BYTE_W-1:0] b, input logic has,
                                            input logic fin);
        t_result r;
        r.packet_type    = cur_type;
        r.send_id        = cur_id;
        r.payload_length = cur_len;
        r.payload_byte   = has ? b : '0;
        r.has_byte       = has;
        r.last           = fin;
        return r;
    endfunction

    task automatic add_due(input t_result r);
        tagged_bytes_due[due_wr] = r;
        due_wr = due_wr + 6'd1;
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        logic [IDX_W-1:0] pos;
        if (in_payload) begin
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == '0) begin
                add_due(make_result(b, 1'b1, 1'b1));
                in_payload = 1'b0;
                hdr_pos    = IDX_TYPE;
            end else begin
                add_due(make_result(b, 1'b1, 1'b0));
            end
        end else begin
            pos = (hdr_pos > IDX_LAST) ? IDX_TYPE : hdr_pos;
            if (pos == IDX_TYPE) begin
                cur_type = b;
            end else if (pos <= IDX_ID_LAST) begin
                cur_id[8*(pos-1) +: 8] = b;
            end else begin
                cur_len[8*(pos-IDX_LEN_LO) +: 8] = b;
            end
            if (pos != IDX_LAST) begin
                hdr_pos = pos + 1'b1;
            end else begin
                hdr_pos = IDX_TYPE;
                if (cur_len == '0) begin
                    add_due(make_result('0, 1'b0, 1'b1));
                end else begin
                    in_payload = 1'b1;
                    bytes_left = cur_len;
                end
            end
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        deframe_byte(b);
    endtask

    task automatic send_header(input logic [BYTE_W-1:0] ptype, input logic [ID_W-1:0] id,
                               input logic [LEN_W-1:0] len);
        send_byte(ptype);
        for (int i = 0; i < 4; i++) begin
            send_byte(id[8*i +: 8]);
        end
        send_byte(len[7:0]);
        send_byte(len[15:8]);
    endtask

    task automatic test_header_extremes();
        // An all-ones empty packet, then a zero type and id header whose single byte is all ones.
        send_header(8'hFF, 32'hFFFF_FFFF, 16'h0000);
        send_header(8'h00, 32'h0000_0000, 16'h0001);
        send_byte(8'hFF);
    endtask

    task automatic test_header_lanes();
        // Every lane of the id differs from the previous header.
        send_header(8'hA5, 32'h1234_5678, 16'h0002);
        send_byte(8'h00);
        send_byte(8'h80);
    endtask

    task automatic test_random_stream(input int n_bytes);
        int               sent;
        int               pick;
        logic [LEN_W-1:0] len;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                len = '0;
            end else if (pick < 85) begin
                len = LEN_W'($urandom_range(12, 1));
            end else if (pick < 97) begin
                len = LEN_W'($urandom_range(64, 13));
            end else begin
                len = LEN_W'($urandom_range(700, 256));
            end
            if (sent + int'(HEADER_BYTES) + int'(len) > n_bytes) begin
                len = '0;
            end
            send_header(BYTE_W'($urandom), $urandom, len);
            for (int i = 0; i < len; i++) begin
                send_byte(BYTE_W'($urandom));
            end
            sent += int'(HEADER_BYTES) + int'(len);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string name, input logic [ID_W-1:0] exp_v,
                               input logic [ID_W-1:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_rd == due_wr) begin
                fail_count++;
                $error("result item with none expected: type 0x%0h id 0x%0h",
                       o_packet_type, o_send_id);
            end else begin
                exp_r  = tagged_bytes_due[due_rd];
                due_rd = due_rd + 6'd1;
                check_field("packet_type", ID_W'(exp_r.packet_type), ID_W'(o_packet_type));
                check_field("send_id", exp_r.send_id, o_send_id);
                check_field("payload_length", ID_W'(exp_r.payload_length),
                            ID_W'(o_payload_length));
                check_field("payload_byte", ID_W'(exp_r.payload_byte), ID_W'(o_payload_byte));
                check_field("has_byte", ID_W'(exp_r.has_byte), ID_W'(o_has_byte));
                check_field("last", ID_W'(exp_r.last), ID_W'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        in_payload    = 1'b0;
        hdr_pos       = IDX_TYPE;
        cur_type      = '0;
        cur_id        = '0;
        cur_len       = '0;
        bytes_left    = '0;
        due_wr        = '0;
        due_rd        = '0;
        fail_count    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 22;
        recv_idle_pct = 55;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_data_byte  <= '0;
        i_out_ready  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_header_extremes();
        test_header_lanes();
        test_random_stream(400);

        send_idle_pct = 55;
        recv_idle_pct = 22;
        test_random_stream(400);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(400);

        i_in_valid <= 1'b0;
        while (due_rd != due_wr) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
